>>> hw/rtl/mean_of_maximum_defuzzifier_top_assert.svh
// Assertion macros for the defuzzifier checker.
`ifndef MEAN_OF_MAXIMUM_DEFUZZIFIER_TOP_ASSERT_SVH
`define MEAN_OF_MAXIMUM_DEFUZZIFIER_TOP_ASSERT_SVH

// Same-cycle implication, sampled at the rising edge, off during reset.
`define MOM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled at the rising edge, off during reset.
`define MOM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mom_pkg.sv
// Package: widths and register codes of the mean-of-maximum defuzzifier.
package mom_pkg;

    localparam int SAMPLE_W = 16;  // membership, Q0.16
    localparam int COORD_W  = 32;  // range_min and crisp_value, signed Q16.16
    localparam int STEP_W   = 31;  // step_width, unsigned Q15.16
    localparam int TOL_W    = 16;  // equal_tolerance, Q0.16
    localparam int CFG_IDX_W = 2;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(655);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_MIN  = 2'd0,
        CFG_STEP_WIDTH = 2'd1,
        CFG_EQUAL_TOL  = 2'd2
    } cfg_reg_t;

endpackage

>>> hw/rtl/mom_tracker.sv
// Peak and first-plateau tracker; issues the plateau span on the last sample.
module mom_tracker
    import mom_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [TOL_W-1:0]                       equal_tolerance,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [SAMPLE_W-1:0]                    membership_sample,
    input  logic                                   last_sample,
    output logic                                   span_valid,
    output logic [$clog2(MAX_SAMPLES):0]           span,
    input  logic                                   span_ready
);

    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int SPAN_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_SAMPLES - 1);

    logic [SAMPLE_W-1:0] peak_level_reg, peak_level_next;
    logic                have_peak_reg, have_peak_next;
    logic [IDX_W-1:0]    sample_index_reg, sample_index_next;
    logic [IDX_W-1:0]    plateau_first_reg, plateau_first_next;
    logic [IDX_W-1:0]    plateau_last_reg, plateau_last_next;
    logic                on_plateau_reg, on_plateau_next;
    logic                span_valid_reg, span_valid_next;
    logic [SPAN_W-1:0]   span_reg, span_next;

    logic                accept;
    logic [SAMPLE_W-1:0] level_diff;
    logic                level_eq;
    logic                level_gt;
    logic                level_lt;

    // Hold input while the span word waits on a full downstream
    assign in_stall = span_valid_reg && !span_ready;
    assign accept   = in_valid && !in_stall;

    // Compare the sample with the peak under the tolerance
    always_comb
    begin
        level_diff = (membership_sample > peak_level_reg)
                   ? membership_sample - peak_level_reg
                   : peak_level_reg - membership_sample;
        level_eq = (level_diff == '0) || (level_diff < equal_tolerance);
        level_gt = (membership_sample > peak_level_reg) && !level_eq;
        level_lt = (membership_sample < peak_level_reg) && !level_eq;
    end

    // Update peak, plateau and index; emit the span on the last sample
    always_comb
    begin
        peak_level_next    = peak_level_reg;
        have_peak_next     = have_peak_reg;
        sample_index_next  = sample_index_reg;
        plateau_first_next = plateau_first_reg;
        plateau_last_next  = plateau_last_reg;
        on_plateau_next    = on_plateau_reg;
        span_valid_next    = span_valid_reg && !span_ready;
        span_next          = span_reg;

        if (accept)
        begin
            priority if (!have_peak_reg || level_gt)
            begin
                peak_level_next    = membership_sample;
                plateau_first_next = sample_index_reg;
                plateau_last_next  = sample_index_reg;
                on_plateau_next    = 1'b1;
            end
            else if (on_plateau_reg && level_eq)
            begin
                plateau_last_next = sample_index_reg;
            end
            else if (level_lt)
            begin
                on_plateau_next = 1'b0;
            end
            else
            begin
                // Equal word after the plateau was broken: hold the plateau
                on_plateau_next = on_plateau_reg;
            end

            span_next = SPAN_W'(plateau_first_next) + SPAN_W'(plateau_last_next)
                      + SPAN_W'(1);

            if (last_sample)
            begin
                // End of scan: restart for the next term
                have_peak_next    = 1'b0;
                on_plateau_next   = 1'b0;
                sample_index_next = '0;
                span_valid_next   = 1'b1;
            end
            else
            begin
                have_peak_next = 1'b1;
                if (sample_index_reg != IDX_MAX)
                begin
                    sample_index_next = sample_index_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_peak_reg    <= 1'b0;
            sample_index_reg <= '0;
            on_plateau_reg   <= 1'b0;
            span_valid_reg   <= 1'b0;
        end
        else
        begin
            have_peak_reg    <= have_peak_next;
            sample_index_reg <= sample_index_next;
            on_plateau_reg   <= on_plateau_next;
            span_valid_reg   <= span_valid_next;
        end
    end

    // Payload registers: overwritten by the first sample of each scan
    always_ff @(posedge clk)
    begin
        peak_level_reg    <= peak_level_next;
        plateau_first_reg <= plateau_first_next;
        plateau_last_reg  <= plateau_last_next;
        span_reg          <= span_next;
    end

    assign span_valid = span_valid_reg;
    assign span       = span_reg;

endmodule

>>> hw/rtl/mom_midpoint.sv
// Midpoint pipeline: span times step, halve, offset by range_min, saturate.
module mom_midpoint
    import mom_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic signed [COORD_W-1:0]          range_min,
    input  logic [STEP_W-1:0]                  step_width,
    input  logic                               span_valid,
    input  logic [$clog2(MAX_SAMPLES):0]       span,
    output logic                               span_ready,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [COORD_W-1:0]          crisp_value
);

    localparam int SPAN_W = $clog2(MAX_SAMPLES) + 1;
    localparam int PROD_W = SPAN_W + STEP_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic signed [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    logic                       prod_valid_reg, prod_valid_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [COORD_W-1:0]  crisp_reg, crisp_next;

    logic                       out_ready;
    logic                       prod_ready;
    logic signed [SUM_W-1:0]    sum;
    logic                       over_pos;
    logic                       over_neg;

    assign out_ready  = !out_valid_reg || !out_stall;
    assign prod_ready = !prod_valid_reg || out_ready;
    assign span_ready = prod_ready;

    // Multiply stage: advance when the product register is free
    always_comb
    begin
        prod_valid_next = prod_valid_reg;
        prod_next       = prod_reg;
        if (prod_ready)
        begin
            prod_valid_next = span_valid;
            prod_next       = PROD_W'(span) * PROD_W'(step_width);
        end
    end

    // Offset and saturate the halved product
    always_comb
    begin
        sum = SUM_W'(range_min) + $signed({2'b00, prod_reg[PROD_W-1:1]});
        over_pos = !sum[SUM_W-1] && (|sum[SUM_W-2:COORD_W-1]);
        over_neg = sum[SUM_W-1] && !(&sum[SUM_W-2:COORD_W-1]);
    end

    // Output stage: hold while stalled, load from the product stage
    always_comb
    begin
        out_valid_next = out_valid_reg;
        crisp_next     = crisp_reg;
        if (out_ready)
        begin
            out_valid_next = prod_valid_reg;
            priority if (over_pos)
            begin
                crisp_next = SAT_MAX;
            end
            else if (over_neg)
            begin
                crisp_next = SAT_MIN;
            end
            else
            begin
                crisp_next = sum[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        crisp_reg <= crisp_next;
    end

    assign out_valid   = out_valid_reg;
    assign crisp_value = crisp_reg;

endmodule

>>> hw/rtl/mean_of_maximum_defuzzifier_top.sv
// Mean-of-maximum defuzzifier: one membership sample per cycle while in_stall
// is low, one crisp value per scan. The block takes a membership sample in
// every cycle that in_valid is high and in_stall is low, and updates the peak
// level and the first plateau at that level in the same cycle. On the sample
// flagged last it passes the plateau span into a three-register pipeline
// (span, product, output); the crisp value is held in the output register until
// it is taken while the output is not stalled; the 31-bit step multiply gets a
// stage of its own. Input stalls only when all three registers hold results
// and the output is stalled. Write configuration only while no scan is open
// and no crisp value is in flight: the tolerance applies to the next sample,
// while the step and range_min are read as a result passes the multiply and
// output stages.
module mean_of_maximum_defuzzifier_top
    import mom_pkg::*;
#(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [COORD_W-1:0]         cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [SAMPLE_W-1:0]        membership_sample,
    input  logic                       last_sample,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [COORD_W-1:0]  crisp_value
);

    localparam int SPAN_W = $clog2(MAX_SAMPLES) + 1;

    logic signed [COORD_W-1:0] range_min_reg;
    logic [STEP_W-1:0]         step_width_reg;
    logic [TOL_W-1:0]          equal_tolerance_reg;

    logic                      span_valid;
    logic [SPAN_W-1:0]         span;
    logic                      span_ready;

    // Configuration registers; out-of-range indexes drop the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg       <= '0;
            step_width_reg      <= STEP_RESET;
            equal_tolerance_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_RANGE_MIN:  range_min_reg       <= $signed(cfg_data);
                CFG_STEP_WIDTH: step_width_reg      <= cfg_data[STEP_W-1:0];
                CFG_EQUAL_TOL:  equal_tolerance_reg <= cfg_data[TOL_W-1:0];
                default:        ;
            endcase
        end
    end

    mom_tracker #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_tracker (
        .clk               (clk),
        .rst_n             (rst_n),
        .equal_tolerance   (equal_tolerance_reg),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .membership_sample (membership_sample),
        .last_sample       (last_sample),
        .span_valid        (span_valid),
        .span              (span),
        .span_ready        (span_ready)
    );

    mom_midpoint #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_midpoint (
        .clk         (clk),
        .rst_n       (rst_n),
        .range_min   (range_min_reg),
        .step_width  (step_width_reg),
        .span_valid  (span_valid),
        .span        (span),
        .span_ready  (span_ready),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .crisp_value (crisp_value)
    );

endmodule

>>> hw/rtl/mom_checker.sv
// Port-level checker for the defuzzifier and its bind to the top level.
`include "mean_of_maximum_defuzzifier_top_assert.svh"

module mom_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] crisp_value
);

    // A stalled result word holds its value
    `MOM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(crisp_value), "stalled result word changed")

    // A result word leaves only after it was taken
    `MOM_ASSERT_IMP(a_out_drop, clk, rst_n, $fell(out_valid), $past(!out_stall),
        "result word dropped while stalled")

    // Input stalls only behind a full, stalled output
    `MOM_ASSERT_IMP(a_stall_src, clk, rst_n, in_stall, out_valid && out_stall,
        "input stalled without output back-pressure")

    // Draining the output with no input word frees the input side
    `MOM_ASSERT_NXT(a_stall_free, clk, rst_n, out_valid && !out_stall && !in_valid,
        !in_stall, "input stalled after output drained")

endmodule

bind mean_of_maximum_defuzzifier_top mom_checker u_mom_checker (.*);

>>> sim/tb_mean_of_maximum_defuzzifier_top.sv
// Self-checking testbench for the mean-of-maximum defuzzifier: directed scans, then random scans.
`timescale 1ns / 1ps

module tb_mean_of_maximum_defuzzifier_top;
    import mom_pkg::*;

    localparam int N_SAMP      = 4096;
    localparam int IDX_W       = $clog2(N_SAMP);
    localparam int RAND_ITEMS  = 550;
    localparam int LONG_SCAN   = 4100;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DIR_ROWS    = 16;

    // index 3 decodes to no register
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [COORD_W-1:0]        cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [SAMPLE_W-1:0]       membership_sample;
    logic                      last_sample;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [COORD_W-1:0] crisp_value;

    mean_of_maximum_defuzzifier_top #(
        .MAX_SAMPLES(N_SAMP)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .membership_sample (membership_sample),
        .last_sample       (last_sample),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .crisp_value       (crisp_value)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Directed scans under the reset configuration
    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                lst;
        bit                  typed;
        logic [COORD_W-1:0]  crisp;
    } dir_row_t;

    dir_row_t dir_tab [DIR_ROWS] = '{
        // single-sample scan right after reset: centre of the first interval
        '{16'h1234, 1'b1, 1'b1, 32'd327},
        // plateau at full scale over indexes 1..2
        '{16'h0000, 1'b0, 1'b0, 32'd0},
        '{16'hFFFF, 1'b0, 1'b0, 32'd0},
        '{16'hFFFF, 1'b0, 1'b0, 32'd0},
        '{16'h0000, 1'b1, 1'b1, 32'd1310},
        // plateau broken by a lower word, later equal word ignored
        '{16'hFFFF, 1'b0, 1'b0, 32'd0},
        '{16'h8000, 1'b0, 1'b0, 32'd0},
        '{16'hFFFF, 1'b1, 1'b1, 32'd327},
        // flat zero scan spans everything
        '{16'h0000, 1'b0, 1'b0, 32'd0},
        '{16'h0000, 1'b0, 1'b0, 32'd0},
        '{16'h0000, 1'b1, 1'b1, 32'd982},
        // higher peak after a dip restarts the plateau
        '{16'h0100, 1'b0, 1'b0, 32'd0},
        '{16'h0050, 1'b0, 1'b0, 32'd0},
        '{16'h0200, 1'b0, 1'b0, 32'd0},
        '{16'h0200, 1'b1, 1'b0, 32'd0},
        '{16'hFFFF, 1'b1, 1'b1, 32'd327}
    };

    // Predictor state and configuration copy
    logic signed [COORD_W-1:0] cfg_rmin;
    logic [STEP_W-1:0]         cfg_step;
    logic [TOL_W-1:0]          cfg_tol;
    logic [SAMPLE_W-1:0]       pk_level;
    bit                        pk_seen;
    logic [IDX_W-1:0]          pos;
    logic [IDX_W-1:0]          span_lo;
    logic [IDX_W-1:0]          span_hi;
    bit                        on_span;

    logic [COORD_W-1:0] crisp_q [$];

    int  errors;
    int  samples;
    int  scans;
    int  checked;
    int  writes;
    int  holds;
    int  cycles;
    int  burst_left;
    bit  no_gaps;
    bit  hold_req;

    // Advance the plateau tracker by one word; return 1 with the crisp value on a last word
    function automatic bit predict_crisp(input logic [SAMPLE_W-1:0] y, input logic lst,
                                         output logic [COORD_W-1:0] crisp);
        logic [SAMPLE_W-1:0] diff;
        bit                  eq;
        logic [IDX_W:0]      n;
        logic [63:0]         prod;
        longint              sum;
        diff = (y > pk_level) ? y - pk_level : pk_level - y;
        eq = (diff == '0) || (diff < cfg_tol);
        if (!pk_seen)
        begin
            pk_seen  = 1'b1;
            pk_level = y;
            span_lo  = pos;
            span_hi  = pos;
            on_span  = 1'b1;
        end
        else if (y > pk_level && !eq)
        begin
            pk_level = y;
            span_lo  = pos;
            span_hi  = pos;
            on_span  = 1'b1;
        end
        else if (on_span && eq)
            span_hi = pos;
        else if (y < pk_level && !eq)
            on_span = 1'b0;
        // index sticks at the top once the scan runs long
        if (pos < IDX_W'(N_SAMP - 1))
            pos = pos + IDX_W'(1);
        crisp = '0;
        if (!lst)
            return 1'b0;
        n = {1'b0, span_lo} + {1'b0, span_hi} + (IDX_W + 1)'(1);
        prod = 64'(n) * 64'(cfg_step);
        sum = longint'(cfg_rmin);
        sum = sum + longint'(prod >> 1);
        crisp = (sum > 64'sd2147483647) ? 32'h7FFF_FFFF : sum[31:0];
        pk_seen = 1'b0;
        on_span = 1'b0;
        pos     = '0;
        return 1'b1;
    endfunction

    // Drive one register write and mirror it in the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_RANGE_MIN:  cfg_rmin = data;
            CFG_STEP_WIDTH: cfg_step = data[STEP_W-1:0];
            CFG_EQUAL_TOL:  cfg_tol  = data[TOL_W-1:0];
            default: ;
        endcase
        writes++;
    endtask

    task automatic set_config(input logic [COORD_W-1:0] rmin_w, input logic [COORD_W-1:0] step_w,
                              input logic [COORD_W-1:0] tol_w);
        logic [COORD_W-1:0] junk;
        junk = $urandom;
        write_reg(CFG_RANGE_MIN, rmin_w);
        write_reg(CFG_STEP_WIDTH, step_w);
        write_reg(CFG_EQUAL_TOL, tol_w);
        write_reg(CFG_NONE, junk);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Pick a random setting, extremes weighted in; upper data bits carry noise
    task automatic pick_config();
        logic [COORD_W-1:0] rmin_w;
        logic [COORD_W-1:0] noise;
        logic [STEP_W-1:0]  step_v;
        logic [TOL_W-1:0]   tol_v;
        noise = $urandom;
        case ($urandom_range(0, 4))
            0:       rmin_w = 32'h8000_0000;
            1:       rmin_w = 32'h7FFF_FFFF;
            2:       rmin_w = 32'($urandom_range(0, 32'h000F_FFFF));
            3:       rmin_w = -32'($urandom_range(0, 32'h000F_FFFF));
            default: rmin_w = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0:       step_v = '0;
            1:       step_v = '1;
            2:       step_v = STEP_W'($urandom_range(1, 1024));
            3:       step_v = STEP_W'($urandom_range(1, 1 << 20));
            default: step_v = STEP_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       tol_v = '0;
            1:       tol_v = TOL_W'($urandom_range(1, 64));
            2:       tol_v = TOL_W'($urandom_range(64, 4096));
            3:       tol_v = '1;
            default: tol_v = TOL_W'($urandom);
        endcase
        set_config(rmin_w, {noise[31], step_v}, {noise[15:0], tol_v});
    endtask

    // Offer one word in bursts with random gaps; predict once it is taken
    task automatic send_word(input logic [SAMPLE_W-1:0] y, input logic lst, input bit typed,
                             input logic [COORD_W-1:0] typed_val);
        int                 gap;
        bit                 got;
        logic [COORD_W-1:0] crisp;
        if (burst_left == 0)
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        in_valid          <= 1'b1;
        membership_sample <= y;
        last_sample       <= lst;
        do
            @(posedge clk);
        while (in_stall);
        got = predict_crisp(y, lst, crisp);
        if (got)
        begin
            crisp_q.push_back(typed ? typed_val : crisp);
            scans++;
        end
        samples++;
    endtask

    // Random scan: plateaus, near-equal words around the tolerance, and noise
    task automatic send_scan(input int len);
        int base;
        int v;
        int d;
        base = $urandom_range(0, 65535);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: v = base;
                4, 5:
                begin
                    d = $urandom_range(0, int'(cfg_tol) + 2);
                    v = ($urandom_range(0, 1) == 1) ? base + d : base - d;
                end
                6:       v = $urandom_range(0, 65535);
                7:       v = 0;
                8:       v = 65535;
                default: v = base - $urandom_range(1, 4096);
            endcase
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
            send_word(SAMPLE_W'(v), (i == len - 1), 1'b0, '0);
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(1, 6);
        if (r < 9)
            return $urandom_range(7, 20);
        return $urandom_range(21, 60);
    endfunction

    // Hold the sender until every crisp value is back, then let the pipe settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (crisp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
        burst_left = 0;
    endtask

    // Receiver: stall pattern that changes mode, plus one long hold-off on request
    initial
    begin : rx_pattern
        int mode;
        int left;
        mode = 0;
        left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                holds++;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(8, 64);
                end
                left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 9) < 7);
                    default: out_stall <= left[2];
                endcase
            end
        end
    end

    // Compare each accepted crisp value with the oldest prediction
    always @(posedge clk)
    begin
        logic [COORD_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (crisp_q.size() == 0)
            begin
                $display("%0t: crisp value with nothing pending: expected none actual %h",
                         $time, crisp_value);
                errors++;
            end
            else
            begin
                want = crisp_q.pop_front();
                if (crisp_value !== want)
                begin
                    $display("%0t: crisp_value wrong: expected %h actual %h",
                             $time, want, crisp_value);
                    errors++;
                end
                checked++;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d crisp values pending",
                     $time, cycles, crisp_q.size());
            $display("mean_of_maximum_defuzzifier_top: mismatch");
            $finish;
        end
    end

    initial
    begin : main
        int start;
        int phase_len;
        logic [SAMPLE_W-1:0] v;
        rst_n             = 1'b0;
        cfg_write         = 1'b0;
        cfg_index         = CFG_RANGE_MIN;
        cfg_data          = '0;
        in_valid          = 1'b0;
        membership_sample = '0;
        last_sample       = 1'b0;
        hold_req          = 1'b0;
        no_gaps           = 1'b0;
        burst_left        = 0;
        errors            = 0;
        samples           = 0;
        scans             = 0;
        checked           = 0;
        writes            = 0;
        holds             = 0;
        cycles            = 0;
        cfg_rmin          = '0;
        cfg_step          = STEP_RESET;
        cfg_tol           = '0;
        pk_level          = '0;
        pk_seen           = 1'b0;
        pos               = '0;
        span_lo           = '0;
        span_hi           = '0;
        on_span           = 1'b0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed table under reset configuration
        for (int i = 0; i < DIR_ROWS; i++)
            send_word(dir_tab[i].sample, dir_tab[i].lst, dir_tab[i].typed, dir_tab[i].crisp);
        drain();

        // Most negative origin, widest step (bit 31 masked off), widest tolerance
        set_config(32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF);
        start = samples;
        while (samples - start < 40)
            send_scan(pick_len());
        drain();

        // Most positive origin, zero step, zero tolerance with noise above
        set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'hABCD_0000);
        start = samples;
        while (samples - start < 30)
            send_scan(pick_len());
        drain();

        // Most positive origin, unit step: saturates as soon as the span grows
        set_config(32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0010);
        start = samples;
        while (samples - start < 30)
            send_scan(pick_len());
        drain();

        // Long hold-off at the output while single-word scans keep coming
        pick_config();
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
            send_word(SAMPLE_W'($urandom), 1'b1, 1'b0, '0);
        no_gaps = 1'b0;
        drain();

        // Over-long scan: the peak sits where the index saturates
        set_config(32'h0000_0000, 32'd655, 32'h0000_0000);
        for (int i = 0; i < LONG_SCAN; i++)
        begin
            v = (i >= N_SAMP - 2) ? 16'hFFFF : SAMPLE_W'($urandom_range(0, 16'h7FFF));
            send_word(v, (i == LONG_SCAN - 1), 1'b0, '0);
        end
        drain();

        // Random phases with a fresh setting each
        start = samples;
        while (samples - start < RAND_ITEMS)
        begin
            pick_config();
            phase_len = samples + $urandom_range(20, 70);
            while (samples < phase_len)
                send_scan(pick_len());
            drain();
        end

        $display("covered %0d words in %0d scans, %0d crisp values compared",
                 samples, scans, checked);
        $display("register writes: %0d, output hold-offs: %0d, mismatches: %0d",
                 writes, holds, errors);
        if (errors == 0)
            $display("mean_of_maximum_defuzzifier_top: match");
        else
            $display("mean_of_maximum_defuzzifier_top: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mom_pkg.sv
hw/rtl/mom_tracker.sv
hw/rtl/mom_midpoint.sv
hw/rtl/mean_of_maximum_defuzzifier_top.sv
hw/rtl/mom_checker.sv
sim/tb_mean_of_maximum_defuzzifier_top.sv
